>>> hw/rtl/hff_pkg.sv
// ----------------------------------------------------------------------------
// hff_pkg
// Shared types, register indexes and character codes for the hex field
// formatter.
// ----------------------------------------------------------------------------
package hff_pkg;

	localparam int ValueW  = 64;
	localparam int CharW   = 8;
	localparam int CfgIdxW = 3;
	localparam int CfgW    = 7;
	localparam int MaxChars = 64;
	localparam int MaxPrec  = 62;

	localparam logic [CfgIdxW-1:0] CFG_FIELD_WIDTH     = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_PRECISION       = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_PRECISION_GIVEN = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_ALTERNATE_FORM  = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_ZERO_PAD        = 3'd4;

	localparam logic [CharW-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CharW-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CharW-1:0] CHAR_X     = 8'h78;
	localparam logic [CharW-1:0] CHAR_A     = 8'h61;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_EMIT
	} hff_state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
	} hff_cmd_t;

	typedef struct packed {
		logic total_zero;
		logic at_last;
		logic out_free;
	} hff_status_t;

	function automatic logic [CharW-1:0] hex_char(input logic [3:0] d);
		logic [CharW-1:0] c;
		if (d < 4'd10) begin
			c = CHAR_ZERO + {4'd0, d};
		end else begin
			c = CHAR_A + {4'd0, d - 4'd10};
		end
		return c;
	endfunction

endpackage

>>> hw/rtl/hff_ctrl.sv
// ----------------------------------------------------------------------------
// hff_ctrl
// Controller: accepts a value, runs setup, then steps the datapath once per
// character until the last is in the output register (none if zero-length).
// ----------------------------------------------------------------------------
module hff_ctrl import hff_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  hff_status_t status,
	output hff_cmd_t    cmd
);

	hff_state_t state_q;
	hff_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		s_tready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = status.total_zero ? ST_IDLE : ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					cmd.step = 1'b1;
					if (status.at_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT && status.out_free && status.at_last |=> state_q == ST_IDLE)
		else $error("controller did not return to idle after last character");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SETUP)
		else $error("accepted value did not enter setup");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SETUP && !status.total_zero |=> !cmd.load)
		else $error("new value taken while a field is still being emitted");

endmodule

>>> hw/rtl/hff_dp.sv
// ----------------------------------------------------------------------------
// hff_dp
// Datapath: configuration registers, field layout computed at setup, a
// down-counting character position and the output register.
// ----------------------------------------------------------------------------
module hff_dp import hff_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_addr,
	input  logic [CfgW-1:0]      cfg_wdata,
	input  logic [ValueW-1:0]    s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [CharW-1:0]     m_tdata,
	output logic                 m_tlast,
	input  hff_cmd_t             cmd,
	output hff_status_t          status
);

	logic [6:0]        width_q;
	logic [5:0]        prec_q;
	logic              pgiven_q;
	logic              alt_q;
	logic              zpad_q;

	logic [ValueW-1:0] value_q;
	logic [4:0]        ndig_q;
	logic [5:0]        body_q;
	logic [6:0]        core_q;
	logic [6:0]        total_q;
	logic              pfx_q;
	logic              zfill_q;
	logic [5:0]        r_q;

	logic              out_valid_q;
	logic [CharW-1:0]  out_char_q;
	logic              out_last_q;

	logic [6:0]        width_sat;
	logic [5:0]        prec_sat;
	logic [3:0]        msn;
	logic              nz;
	logic [4:0]        ndig_c;
	logic [5:0]        body_c;
	logic              pfx_c;
	logic [6:0]        core_c;
	logic [6:0]        total_c;
	logic [6:0]        r7;
	logic [CharW-1:0]  char_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= '0;
			prec_q   <= '0;
			pgiven_q <= 1'b0;
			alt_q    <= 1'b0;
			zpad_q   <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_FIELD_WIDTH:     width_q  <= cfg_wdata;
				CFG_PRECISION:       prec_q   <= cfg_wdata[5:0];
				CFG_PRECISION_GIVEN: pgiven_q <= cfg_wdata[0];
				CFG_ALTERNATE_FORM:  alt_q    <= cfg_wdata[0];
				CFG_ZERO_PAD:        zpad_q   <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		width_sat = (width_q > 7'(MaxChars)) ? 7'(MaxChars) : width_q;
		prec_sat  = (prec_q > 6'(MaxPrec)) ? 6'(MaxPrec) : prec_q;
		nz        = |value_q;
		msn       = '0;
		for (int i = 0; i < ValueW / 4; i++) begin
			if (|value_q[4*i +: 4]) begin
				msn = 4'(i);
			end
		end
		if (pgiven_q && prec_sat == 6'd0 && !nz) begin
			ndig_c = '0;
		end else begin
			ndig_c = {1'b0, msn} + 5'd1;
		end
		body_c  = (pgiven_q && prec_sat > {1'b0, ndig_c}) ? prec_sat : {1'b0, ndig_c};
		pfx_c   = alt_q && nz;
		core_c  = {1'b0, body_c} + (pfx_c ? 7'd2 : 7'd0);
		total_c = (width_sat > core_c) ? width_sat : core_c;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= s_tdata;
		end
		if (cmd.setup) begin
			ndig_q  <= ndig_c;
			body_q  <= body_c;
			core_q  <= core_c;
			total_q <= total_c;
			pfx_q   <= pfx_c;
			zfill_q <= zpad_q && !pgiven_q;
			r_q     <= 6'(total_c - 7'd1);
		end else if (cmd.step) begin
			r_q     <= r_q - 6'd1;
		end
	end

	always_comb begin
		r7 = {1'b0, r_q};
		if (r7 < {2'b00, ndig_q}) begin
			char_c = hex_char(value_q[{r_q[3:0], 2'b00} +: 4]);
		end else if (r7 < {1'b0, body_q}) begin
			char_c = CHAR_ZERO;
		end else if (zfill_q) begin
			char_c = (pfx_q && r7 == total_q - 7'd2) ? CHAR_X : CHAR_ZERO;
		end else if (r7 < core_q) begin
			char_c = (pfx_q && r7 == core_q - 7'd2) ? CHAR_X : CHAR_ZERO;
		end else begin
			char_c = CHAR_SPACE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			out_char_q <= char_c;
			out_last_q <= (r_q == 6'd0);
		end
	end

	assign status.total_zero = (total_c == 7'd0);
	assign status.at_last    = (r_q == 6'd0);
	assign status.out_free   = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tlast  = out_last_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> status.out_free)
		else $error("character stepped into a full output register");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && r_q == 6'd0 |=> m_tvalid && m_tlast)
		else $error("final character not marked last");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.setup && !status.total_zero |=> ({1'b0, r_q} + 7'd1) == total_q)
		else $error("position counter not loaded with field length");

endmodule

>>> hw/rtl/hex_field_formatter_top.sv
// ----------------------------------------------------------------------------
// hex_field_formatter_top
// Formats a 64-bit value as a printf-style lowercase hex field, one ASCII
// character per output transaction.
// ----------------------------------------------------------------------------
// After accept the controller runs setup, then emit, whose first step places
// the first character in the output register. Throughput: one character per
// cycle while the output register is free, for fields of up to 64 characters;
// a new value is accepted only in idle, and zero-length fields emit nothing.
// Reset: arst_n clears configuration to zero and returns the controller to
// idle with the output register empty.
// ----------------------------------------------------------------------------
module hex_field_formatter_top import hff_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CfgIdxW-1:0] cfg_addr,
	input  logic [CfgW-1:0]    cfg_wdata,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [ValueW-1:0]  s_tdata,   // [63:0] value
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [CharW-1:0]   m_tdata,   // [7:0] out_char
	output logic               m_tlast
);

	hff_cmd_t    cmd;
	hff_status_t status;

	hff_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	hff_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
